// ----- design/rqc_pkg.sv -----
// Shared types and constants for the request admission quota control block.
// Holds the field widths, status and register codes, the controller state
// type and the command and status structs used by rqc_ctrl and rqc_datapath.
package rqc_pkg;

    localparam int ID_W       = 4;
    localparam int ID_NUM     = 2 ** ID_W;
    localparam int STATUS_W   = 3;
    localparam int CNT_W      = 8;
    localparam int TOT_W      = 9;
    localparam int REJ_W      = 32;
    localparam int ACT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int DEF_NUM_OWNERS       = 16;
    localparam int DEF_NUM_SESSIONS     = 16;
    localparam int DEF_TAGS_PER_SESSION = 16;

    localparam logic [CNT_W-1:0] RST_OWNER_READ_LIMIT  = CNT_W'(4);
    localparam logic [CNT_W-1:0] RST_OWNER_WRITE_LIMIT = CNT_W'(2);
    localparam logic [TOT_W-1:0] RST_GLOBAL_READ_LIMIT  = TOT_W'(64);
    localparam logic [TOT_W-1:0] RST_GLOBAL_WRITE_LIMIT = TOT_W'(16);

    typedef enum logic [STATUS_W-1:0] {
        ST_ADMITTED      = 3'd0,
        ST_DUPLICATE     = 3'd1,
        ST_OWNER_LIMIT   = 3'd2,
        ST_GLOBAL_LIMIT  = 3'd3,
        ST_RELEASED      = 3'd4,
        ST_NOT_IN_FLIGHT = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWNER_READ_LIMIT   = 2'd0,
        CFG_OWNER_WRITE_LIMIT  = 2'd1,
        CFG_GLOBAL_READ_LIMIT  = 2'd2,
        CFG_GLOBAL_WRITE_LIMIT = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] writes;
        logic [CNT_W-1:0] reads;
    } t_owner_cnt;

    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_sts;

endpackage

// ----- design/rqc_ctrl.sv -----
// Controller for the request admission quota control block.
// Sequences the clearing pass after reset and each accept-and-update request.
// Depends on rqc_pkg.
module rqc_ctrl import rqc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output logic   o_busy,
    output logic   o_valid
);

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd.clear = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        o_busy      = 1'b1;
        n_valid     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_valid    = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    assign o_valid = r_valid;

    // Every update cycle produces exactly one result strobe right after it.
    a_exec_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> r_valid)
        else $error("update cycle not followed by a result strobe");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_IDLE)
        else $error("result strobe outside the idle state");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state == S_EXEC)
        else $error("accepted request did not enter the update cycle");

endmodule

// ----- design/rqc_datapath.sv -----
// Datapath for the request admission quota control block: limit registers,
// count and tag memories, quota checks, totals, peaks and reject counters.
// Depends on rqc_pkg; driven by commands from rqc_ctrl.
module rqc_datapath import rqc_pkg::*; #(
    parameter int NUM_OWNERS       = DEF_NUM_OWNERS,
    parameter int NUM_SESSIONS     = DEF_NUM_SESSIONS,
    parameter int TAGS_PER_SESSION = DEF_TAGS_PER_SESSION
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_func,
    input  logic                  i_kind,
    input  logic [ID_W-1:0]       i_owner_id,
    input  logic [ID_W-1:0]       i_session_id,
    input  logic [ID_W-1:0]       i_request_tag,
    output logic [STATUS_W-1:0]   o_status,
    output logic [CNT_W-1:0]      o_owner_outstanding,
    output logic [TOT_W-1:0]      o_global_reads_now,
    output logic [TOT_W-1:0]      o_global_writes_now,
    output logic [TOT_W-1:0]      o_read_peak,
    output logic [TOT_W-1:0]      o_write_peak,
    output logic [REJ_W-1:0]      o_owner_reject_total,
    output logic [REJ_W-1:0]      o_global_reject_total,
    output logic [ACT_W-1:0]      o_active_owner_count,
    output logic [ACT_W-1:0]      o_active_session_count
);

    localparam int OW        = (NUM_OWNERS > 1) ? $clog2(NUM_OWNERS) : 1;
    localparam int SSW       = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
    localparam int TW        = (TAGS_PER_SESSION > 1) ? $clog2(TAGS_PER_SESSION) : 1;
    localparam int SLOTS     = NUM_SESSIONS * TAGS_PER_SESSION;
    localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CLR_DEPTH = (NUM_OWNERS > SLOTS) ? NUM_OWNERS : SLOTS;
    localparam int CW        = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
    localparam int SCW       = $clog2(TAGS_PER_SESSION + 1);
    localparam int BOW       = $clog2(NUM_OWNERS + 1);
    localparam int BSW       = $clog2(NUM_SESSIONS + 1);

    // Field values beyond the configured sizes wrap around; these are fixed tables.
    logic [OW-1:0]  owner_map [ID_NUM];
    logic [SSW-1:0] sess_map  [ID_NUM];
    logic [TW-1:0]  tag_map   [ID_NUM];

    for (genvar gi = 0; gi < ID_NUM; gi++) begin : g_map
        assign owner_map[gi] = OW'(gi % NUM_OWNERS);
        assign sess_map[gi]  = SSW'(gi % NUM_SESSIONS);
        assign tag_map[gi]   = TW'(gi % TAGS_PER_SESSION);
    end

    logic [OW-1:0]  a_owner;
    logic [SSW-1:0] a_sess;
    logic [SW-1:0]  a_slot;

    assign a_owner = owner_map[i_owner_id];
    assign a_sess  = sess_map[i_session_id];
    assign a_slot  = SW'(int'(a_sess) * TAGS_PER_SESSION + int'(tag_map[i_request_tag]));

    // Configuration registers.
    logic [CNT_W-1:0] r_owner_rd_lim;
    logic [CNT_W-1:0] r_owner_wr_lim;
    logic [TOT_W-1:0] r_glob_rd_lim;
    logic [TOT_W-1:0] r_glob_wr_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_rd_lim <= RST_OWNER_READ_LIMIT;
            r_owner_wr_lim <= RST_OWNER_WRITE_LIMIT;
            r_glob_rd_lim  <= RST_GLOBAL_READ_LIMIT;
            r_glob_wr_lim  <= RST_GLOBAL_WRITE_LIMIT;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_OWNER_READ_LIMIT:   r_owner_rd_lim <= i_cfg_data[CNT_W-1:0];
                CFG_OWNER_WRITE_LIMIT:  r_owner_wr_lim <= i_cfg_data[CNT_W-1:0];
                CFG_GLOBAL_READ_LIMIT:  r_glob_rd_lim  <= i_cfg_data[TOT_W-1:0];
                CFG_GLOBAL_WRITE_LIMIT: r_glob_wr_lim  <= i_cfg_data[TOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clearing sweep after reset.
    logic [CW-1:0] r_clr_cnt;
    logic          clr_owner;
    logic          clr_sess;
    logic          clr_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + CW'(1);
        end
    end

    assign o_sts.clear_last = (r_clr_cnt == CW'(CLR_DEPTH - 1));
    assign clr_owner = i_cmd.clear && (int'(r_clr_cnt) < NUM_OWNERS);
    assign clr_sess  = i_cmd.clear && (int'(r_clr_cnt) < NUM_SESSIONS);
    assign clr_slot  = i_cmd.clear && (int'(r_clr_cnt) < SLOTS);

    // Request captured at acceptance.
    logic          r_func;
    logic          r_kind;
    logic [OW-1:0]  r_owner;
    logic [SSW-1:0] r_sess;
    logic [SW-1:0]  r_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_kind  <= i_kind;
            r_owner <= a_owner;
            r_sess  <= a_sess;
            r_slot  <= a_slot;
        end
    end

    // Memories: read at acceptance, written back in the update cycle.
    t_owner_cnt     owner_mem [NUM_OWNERS];
    logic           tag_mem   [SLOTS];
    logic [SCW-1:0] sess_mem  [NUM_SESSIONS];

    t_owner_cnt     r_owner_rd;
    logic           r_tag_rd;
    logic [SCW-1:0] r_sess_rd;

    logic           owner_we;
    logic [OW-1:0]  owner_wa;
    t_owner_cnt     owner_wd;
    logic           tag_we;
    logic [SW-1:0]  tag_wa;
    logic           tag_wd;
    logic           sess_we;
    logic [SSW-1:0] sess_wa;
    logic [SCW-1:0] sess_wd;

    always_ff @(posedge i_clk) begin
        if (owner_we) begin
            owner_mem[owner_wa] <= owner_wd;
        end
        if (i_cmd.load) begin
            r_owner_rd <= owner_mem[a_owner];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            tag_mem[tag_wa] <= tag_wd;
        end
        if (i_cmd.load) begin
            r_tag_rd <= tag_mem[a_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sess_we) begin
            sess_mem[sess_wa] <= sess_wd;
        end
        if (i_cmd.load) begin
            r_sess_rd <= sess_mem[a_sess];
        end
    end

    // Scalar state.
    logic [TOT_W-1:0] r_tot_rd;
    logic [TOT_W-1:0] r_tot_wr;
    logic [TOT_W-1:0] r_rd_peak;
    logic [TOT_W-1:0] r_wr_peak;
    logic [REJ_W-1:0] r_owner_rej;
    logic [REJ_W-1:0] r_glob_rej;
    logic [BOW-1:0]   r_busy_owners;
    logic [BSW-1:0]   r_busy_sess;
    t_status          r_status;
    logic [CNT_W-1:0] r_owner_out;

    logic [TOT_W-1:0] n_tot_rd;
    logic [TOT_W-1:0] n_tot_wr;
    logic [TOT_W-1:0] n_rd_peak;
    logic [TOT_W-1:0] n_wr_peak;
    logic [REJ_W-1:0] n_owner_rej;
    logic [REJ_W-1:0] n_glob_rej;
    logic [BOW-1:0]   n_busy_owners;
    logic [BSW-1:0]   n_busy_sess;
    t_status          n_status;
    logic [CNT_W-1:0] n_cnt;
    t_owner_cnt       n_owner;
    logic [SCW-1:0]   n_sess;

    logic [CNT_W-1:0] ocount;
    logic [CNT_W-1:0] olimit;
    logic [TOT_W-1:0] gcount;
    logic [TOT_W-1:0] glimit;
    logic [TOT_W-1:0] n_gcnt;
    logic             admit;
    logic             rel;
    logic             was_busy;
    logic             now_busy;

    always_comb begin
        ocount = r_kind ? r_owner_rd.writes : r_owner_rd.reads;
        olimit = r_kind ? r_owner_wr_lim : r_owner_rd_lim;
        gcount = r_kind ? r_tot_wr : r_tot_rd;
        glimit = r_kind ? r_glob_wr_lim : r_glob_rd_lim;

        // Admit checks run in priority order: duplicate, owner quota, global quota.
        if (!r_func) begin
            if (r_tag_rd) begin
                n_status = ST_DUPLICATE;
            end else if (ocount >= olimit) begin
                n_status = ST_OWNER_LIMIT;
            end else if (gcount >= glimit) begin
                n_status = ST_GLOBAL_LIMIT;
            end else begin
                n_status = ST_ADMITTED;
            end
        end else if (!r_tag_rd) begin
            n_status = ST_NOT_IN_FLIGHT;
        end else begin
            n_status = ST_RELEASED;
        end

        admit = (n_status == ST_ADMITTED);
        rel   = (n_status == ST_RELEASED);

        // A release trusts the given owner and kind, so counts floor at zero.
        if (admit) begin
            n_cnt  = ocount + CNT_W'(1);
            n_gcnt = gcount + TOT_W'(1);
            n_sess = r_sess_rd + SCW'(1);
        end else if (rel) begin
            n_cnt  = (ocount == '0) ? '0 : ocount - CNT_W'(1);
            n_gcnt = (gcount == '0) ? '0 : gcount - TOT_W'(1);
            n_sess = (r_sess_rd == '0) ? '0 : r_sess_rd - SCW'(1);
        end else begin
            n_cnt  = ocount;
            n_gcnt = gcount;
            n_sess = r_sess_rd;
        end

        n_owner = r_owner_rd;
        if (r_kind) begin
            n_owner.writes = n_cnt;
        end else begin
            n_owner.reads = n_cnt;
        end

        n_tot_rd  = r_kind ? r_tot_rd : n_gcnt;
        n_tot_wr  = r_kind ? n_gcnt : r_tot_wr;
        n_rd_peak = (n_tot_rd > r_rd_peak) ? n_tot_rd : r_rd_peak;
        n_wr_peak = (n_tot_wr > r_wr_peak) ? n_tot_wr : r_wr_peak;

        n_owner_rej = r_owner_rej;
        if (n_status == ST_OWNER_LIMIT && r_owner_rej != '1) begin
            n_owner_rej = r_owner_rej + REJ_W'(1);
        end
        n_glob_rej = r_glob_rej;
        if (n_status == ST_GLOBAL_LIMIT && r_glob_rej != '1) begin
            n_glob_rej = r_glob_rej + REJ_W'(1);
        end

        n_busy_sess = r_busy_sess;
        if (admit && r_sess_rd == '0) begin
            n_busy_sess = r_busy_sess + BSW'(1);
        end else if (rel && n_sess == '0 && r_busy_sess != '0) begin
            n_busy_sess = r_busy_sess - BSW'(1);
        end

        was_busy = (r_owner_rd != '0);
        now_busy = (n_owner != '0);
        n_busy_owners = r_busy_owners;
        if (now_busy && !was_busy) begin
            n_busy_owners = r_busy_owners + BOW'(1);
        end else if (!now_busy && was_busy && r_busy_owners != '0) begin
            n_busy_owners = r_busy_owners - BOW'(1);
        end
    end

    always_comb begin
        owner_we = clr_owner || (i_cmd.exec && (admit || rel));
        owner_wa = i_cmd.clear ? r_clr_cnt[OW-1:0] : r_owner;
        owner_wd = i_cmd.clear ? '0 : n_owner;
        tag_we   = clr_slot || (i_cmd.exec && (admit || rel));
        tag_wa   = i_cmd.clear ? r_clr_cnt[SW-1:0] : r_slot;
        tag_wd   = i_cmd.clear ? 1'b0 : admit;
        sess_we  = clr_sess || (i_cmd.exec && (admit || rel));
        sess_wa  = i_cmd.clear ? r_clr_cnt[SSW-1:0] : r_sess;
        sess_wd  = i_cmd.clear ? '0 : n_sess;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_rd      <= '0;
            r_tot_wr      <= '0;
            r_rd_peak     <= '0;
            r_wr_peak     <= '0;
            r_owner_rej   <= '0;
            r_glob_rej    <= '0;
            r_busy_owners <= '0;
            r_busy_sess   <= '0;
        end else if (i_cmd.exec) begin
            r_tot_rd      <= n_tot_rd;
            r_tot_wr      <= n_tot_wr;
            r_rd_peak     <= n_rd_peak;
            r_wr_peak     <= n_wr_peak;
            r_owner_rej   <= n_owner_rej;
            r_glob_rej    <= n_glob_rej;
            r_busy_owners <= n_busy_owners;
            r_busy_sess   <= n_busy_sess;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_owner_out <= n_cnt;
        end
    end

    assign o_status               = r_status;
    assign o_owner_outstanding    = r_owner_out;
    assign o_global_reads_now     = r_tot_rd;
    assign o_global_writes_now    = r_tot_wr;
    assign o_read_peak            = r_rd_peak;
    assign o_write_peak           = r_wr_peak;
    assign o_owner_reject_total   = r_owner_rej;
    assign o_global_reject_total  = r_glob_rej;
    assign o_active_owner_count   = ACT_W'(r_busy_owners);
    assign o_active_session_count = ACT_W'(r_busy_sess);

    // The high-water marks must always cover the live totals.
    a_rd_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tot_rd <= r_rd_peak)
        else $error("read total above its high-water mark");

    a_wr_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tot_wr <= r_wr_peak)
        else $error("write total above its high-water mark");

    a_rej_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_owner_rej >= $past(r_owner_rej))
        else $error("owner reject counter went backward");

endmodule

// ----- design/request_admission_quota_control.sv -----
// Request admission quota control: admits and releases read and write requests
// against per-owner and global outstanding limits, tracking in-flight tags.
// Depends on rqc_pkg, rqc_ctrl and rqc_datapath.
//
// Usage: a request (func, kind, owner, session, tag) is taken at a rising edge
// where start is high and busy is low. Busy then stays high for one update
// cycle, in which the tag, owner count and session count memories read at
// acceptance are checked and written back. The result is registered at the
// end of that update cycle and appears on the output ports with o_valid high
// for exactly one cycle; it must be taken then, as there is no back-pressure.
// A new request can be taken in the same cycle the result is shown, but not
// while busy is high, as each request reads the state memories at acceptance
// and writes them back in the update cycle.
// Limit registers are written through i_cfg_we, i_cfg_idx and i_cfg_data at
// any edge, without wait; index 0..3 selects owner read, owner write, global
// read and global write limit.
// After reset the block runs a clearing pass over every entry of its memories,
// during which busy is high and no request is taken.
module request_admission_quota_control import rqc_pkg::*; #(
    parameter int NUM_OWNERS       = DEF_NUM_OWNERS,
    parameter int NUM_SESSIONS     = DEF_NUM_SESSIONS,
    parameter int TAGS_PER_SESSION = DEF_TAGS_PER_SESSION
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  o_valid,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_func,
    input  logic                  i_kind,
    input  logic [ID_W-1:0]       i_owner_id,
    input  logic [ID_W-1:0]       i_session_id,
    input  logic [ID_W-1:0]       i_request_tag,
    output logic [STATUS_W-1:0]   o_status,
    output logic [CNT_W-1:0]      o_owner_outstanding,
    output logic [TOT_W-1:0]      o_global_reads_now,
    output logic [TOT_W-1:0]      o_global_writes_now,
    output logic [TOT_W-1:0]      o_read_peak,
    output logic [TOT_W-1:0]      o_write_peak,
    output logic [REJ_W-1:0]      o_owner_reject_total,
    output logic [REJ_W-1:0]      o_global_reject_total,
    output logic [ACT_W-1:0]      o_active_owner_count,
    output logic [ACT_W-1:0]      o_active_session_count
);

    t_cmd cmd;
    t_sts sts;

    rqc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    rqc_datapath #(
        .NUM_OWNERS       (NUM_OWNERS),
        .NUM_SESSIONS     (NUM_SESSIONS),
        .TAGS_PER_SESSION (TAGS_PER_SESSION)
    ) u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_data             (i_cfg_data),
        .i_func                 (i_func),
        .i_kind                 (i_kind),
        .i_owner_id             (i_owner_id),
        .i_session_id           (i_session_id),
        .i_request_tag          (i_request_tag),
        .o_status               (o_status),
        .o_owner_outstanding    (o_owner_outstanding),
        .o_global_reads_now     (o_global_reads_now),
        .o_global_writes_now    (o_global_writes_now),
        .o_read_peak            (o_read_peak),
        .o_write_peak           (o_write_peak),
        .o_owner_reject_total   (o_owner_reject_total),
        .o_global_reject_total  (o_global_reject_total),
        .o_active_owner_count   (o_active_owner_count),
        .o_active_session_count (o_active_session_count)
    );

endmodule

// ----- dv/testbench.sv -----
// Testbench for request_admission_quota_control: directed and random admit and release
// requests under several limit settings, each result checked against a cycle-free predictor.
// Depends on rqc_pkg and the request_admission_quota_control RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rqc_pkg::*;

    localparam int  SLOTS          = ID_NUM * ID_NUM;
    localparam int  SETTLE_CYCLES  = 4;
    localparam int  WATCHDOG_LIMIT = 1000;
    localparam int  PHASE_REQUESTS = 150;
    localparam logic FUNC_ADMIT    = 1'b0;
    localparam logic FUNC_RELEASE  = 1'b1;
    localparam logic KIND_READ     = 1'b0;
    localparam logic KIND_WRITE    = 1'b1;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] owner_out;
        logic [TOT_W-1:0] reads_now;
        logic [TOT_W-1:0] writes_now;
        logic [TOT_W-1:0] read_peak;
        logic [TOT_W-1:0] write_peak;
        logic [REJ_W-1:0] owner_rej;
        logic [REJ_W-1:0] global_rej;
        logic [ACT_W-1:0] active_owners;
        logic [ACT_W-1:0] active_sessions;
    } t_quota_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  o_valid;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_func = 1'b0;
    logic                  i_kind = 1'b0;
    logic [ID_W-1:0]       i_owner_id = '0;
    logic [ID_W-1:0]       i_session_id = '0;
    logic [ID_W-1:0]       i_request_tag = '0;
    logic [STATUS_W-1:0]   o_status;
    logic [CNT_W-1:0]      o_owner_outstanding;
    logic [TOT_W-1:0]      o_global_reads_now;
    logic [TOT_W-1:0]      o_global_writes_now;
    logic [TOT_W-1:0]      o_read_peak;
    logic [TOT_W-1:0]      o_write_peak;
    logic [REJ_W-1:0]      o_owner_reject_total;
    logic [REJ_W-1:0]      o_global_reject_total;
    logic [ACT_W-1:0]      o_active_owner_count;
    logic [ACT_W-1:0]      o_active_session_count;

    // Quota state as the block should hold it.
    logic [CNT_W-1:0] lim_owner_read   = RST_OWNER_READ_LIMIT;
    logic [CNT_W-1:0] lim_owner_write  = RST_OWNER_WRITE_LIMIT;
    logic [TOT_W-1:0] lim_global_read  = RST_GLOBAL_READ_LIMIT;
    logic [TOT_W-1:0] lim_global_write = RST_GLOBAL_WRITE_LIMIT;
    logic [CNT_W-1:0] held_reads [ID_NUM] = '{default: '0};
    logic [CNT_W-1:0] held_writes [ID_NUM] = '{default: '0};
    logic [ACT_W-1:0] session_tags [ID_NUM] = '{default: '0};
    logic             tag_busy [SLOTS] = '{default: 1'b0};
    logic [ID_W-1:0]  holder_owner [SLOTS] = '{default: '0};
    logic             holder_kind [SLOTS] = '{default: 1'b0};
    logic [TOT_W-1:0] reads_total = '0;
    logic [TOT_W-1:0] writes_total = '0;
    logic [TOT_W-1:0] reads_high = '0;
    logic [TOT_W-1:0] writes_high = '0;
    logic [REJ_W-1:0] owner_reject_cnt = '0;
    logic [REJ_W-1:0] global_reject_cnt = '0;
    logic [ACT_W-1:0] owners_busy = '0;
    logic [ACT_W-1:0] sessions_busy = '0;

    t_quota_result pending_results [$];
    int            mismatch_count = 0;
    int            requests_taken = 0;
    int            results_seen = 0;
    int            settings_used = 0;
    int            stall_cycles = 0;
    int            status_hits [6] = '{default: 0};
    bit            idle_gaps = 1'b0;

    request_admission_quota_control u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .start                  (start),
        .busy                   (busy),
        .o_valid                (o_valid),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_data             (i_cfg_data),
        .i_func                 (i_func),
        .i_kind                 (i_kind),
        .i_owner_id             (i_owner_id),
        .i_session_id           (i_session_id),
        .i_request_tag          (i_request_tag),
        .o_status               (o_status),
        .o_owner_outstanding    (o_owner_outstanding),
        .o_global_reads_now     (o_global_reads_now),
        .o_global_writes_now    (o_global_writes_now),
        .o_read_peak            (o_read_peak),
        .o_write_peak           (o_write_peak),
        .o_owner_reject_total   (o_owner_reject_total),
        .o_global_reject_total  (o_global_reject_total),
        .o_active_owner_count   (o_active_owner_count),
        .o_active_session_count (o_active_session_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one request to the quota state and returns the result it should produce.
    function automatic t_quota_result predict_request(logic func, logic kind,
            logic [ID_W-1:0] owner, logic [ID_W-1:0] session, logic [ID_W-1:0] tag);
        t_quota_result    r;
        logic [7:0]       slot;
        logic [CNT_W-1:0] own_cnt;
        logic [CNT_W-1:0] own_lim;
        logic [TOT_W-1:0] tot_cnt;
        logic [TOT_W-1:0] tot_lim;
        logic             was_busy;
        logic             now_busy;
        slot     = {session, tag};
        was_busy = (held_reads[owner] != 0) || (held_writes[owner] != 0);
        own_cnt  = (kind == KIND_WRITE) ? held_writes[owner] : held_reads[owner];
        own_lim  = (kind == KIND_WRITE) ? lim_owner_write : lim_owner_read;
        tot_cnt  = (kind == KIND_WRITE) ? writes_total : reads_total;
        tot_lim  = (kind == KIND_WRITE) ? lim_global_write : lim_global_read;
        if (func == FUNC_ADMIT) begin
            if (tag_busy[slot]) begin
                r.status = ST_DUPLICATE;
            end else if (own_cnt >= own_lim) begin
                if (owner_reject_cnt != '1) owner_reject_cnt++;
                r.status = ST_OWNER_LIMIT;
            end else if (tot_cnt >= tot_lim) begin
                if (global_reject_cnt != '1) global_reject_cnt++;
                r.status = ST_GLOBAL_LIMIT;
            end else begin
                if (kind == KIND_WRITE) begin
                    held_writes[owner]++;
                    writes_total++;
                    if (writes_total > writes_high) writes_high = writes_total;
                end else begin
                    held_reads[owner]++;
                    reads_total++;
                    if (reads_total > reads_high) reads_high = reads_total;
                end
                tag_busy[slot]     = 1'b1;
                holder_owner[slot] = owner;
                holder_kind[slot]  = kind;
                if (session_tags[session] == 0) sessions_busy++;
                session_tags[session]++;
                r.status = ST_ADMITTED;
            end
        end else if (!tag_busy[slot]) begin
            r.status = ST_NOT_IN_FLIGHT;
        end else begin
            // The release trusts the owner and kind it names; counts stop at zero.
            if (kind == KIND_WRITE) begin
                if (held_writes[owner] != 0) held_writes[owner]--;
                if (writes_total != 0) writes_total--;
            end else begin
                if (held_reads[owner] != 0) held_reads[owner]--;
                if (reads_total != 0) reads_total--;
            end
            tag_busy[slot] = 1'b0;
            if (session_tags[session] != 0) session_tags[session]--;
            if (session_tags[session] == 0 && sessions_busy != 0) sessions_busy--;
            r.status = ST_RELEASED;
        end
        now_busy = (held_reads[owner] != 0) || (held_writes[owner] != 0);
        if (now_busy && !was_busy) begin
            owners_busy++;
        end else if (!now_busy && was_busy && owners_busy != 0) begin
            owners_busy--;
        end
        r.owner_out       = (kind == KIND_WRITE) ? held_writes[owner] : held_reads[owner];
        r.reads_now       = reads_total;
        r.writes_now      = writes_total;
        r.read_peak       = reads_high;
        r.write_peak      = writes_high;
        r.owner_rej       = owner_reject_cnt;
        r.global_rej      = global_reject_cnt;
        r.active_owners   = owners_busy;
        r.active_sessions = sessions_busy;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
                 $time, what, got, want, results_seen);
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_quota_result seen;
        t_quota_result due;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                seen.status          = t_status'(o_status);
                seen.owner_out       = o_owner_outstanding;
                seen.reads_now       = o_global_reads_now;
                seen.writes_now      = o_global_writes_now;
                seen.read_peak       = o_read_peak;
                seen.write_peak      = o_write_peak;
                seen.owner_rej       = o_owner_reject_total;
                seen.global_rej      = o_global_reject_total;
                seen.active_owners   = o_active_owner_count;
                seen.active_sessions = o_active_session_count;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request pending", 32'(seen.status), '0);
                end else begin
                    due = pending_results.pop_front();
                    check_field("status", 32'(seen.status), 32'(due.status));
                    check_field("owner_outstanding", 32'(seen.owner_out),
                                32'(due.owner_out));
                    check_field("global_reads_now", 32'(seen.reads_now),
                                32'(due.reads_now));
                    check_field("global_writes_now", 32'(seen.writes_now),
                                32'(due.writes_now));
                    check_field("read_peak", 32'(seen.read_peak), 32'(due.read_peak));
                    check_field("write_peak", 32'(seen.write_peak), 32'(due.write_peak));
                    check_field("owner_reject_total", seen.owner_rej, due.owner_rej);
                    check_field("global_reject_total", seen.global_rej, due.global_rej);
                    check_field("active_owner_count", 32'(seen.active_owners),
                                32'(due.active_owners));
                    check_field("active_session_count", 32'(seen.active_sessions),
                                32'(due.active_sessions));
                end
                results_seen++;
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_OWNER_READ_LIMIT:   lim_owner_read   = i_cfg_data[CNT_W-1:0];
                    CFG_OWNER_WRITE_LIMIT:  lim_owner_write  = i_cfg_data[CNT_W-1:0];
                    CFG_GLOBAL_READ_LIMIT:  lim_global_read  = i_cfg_data[TOT_W-1:0];
                    CFG_GLOBAL_WRITE_LIMIT: lim_global_write = i_cfg_data[TOT_W-1:0];
                    default: ;
                endcase
            end
            if (start && busy === 1'b0) begin
                due = predict_request(i_func, i_kind, i_owner_id, i_session_id, i_request_tag);
                status_hits[int'(due.status)]++;
                pending_results.push_back(due);
                requests_taken++;
            end
        end
    end

    // Any accepted request or delivered result counts as progress.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no progress, %0d results outstanding",
                     $time, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(logic func, logic kind, logic [ID_W-1:0] owner,
                                logic [ID_W-1:0] session, logic [ID_W-1:0] tag);
        if (idle_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= func;
        i_kind        <= kind;
        i_owner_id    <= owner;
        i_session_id  <= session;
        i_request_tag <= tag;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy !== 1'b0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_limits(logic [CFG_DATA_W-1:0] own_rd, logic [CFG_DATA_W-1:0] own_wr,
                                logic [CFG_DATA_W-1:0] glb_rd, logic [CFG_DATA_W-1:0] glb_wr);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OWNER_READ_LIMIT;
        i_cfg_data <= own_rd;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_OWNER_WRITE_LIMIT;
        i_cfg_data <= own_wr;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_GLOBAL_READ_LIMIT;
        i_cfg_data <= glb_rd;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_GLOBAL_WRITE_LIMIT;
        i_cfg_data <= glb_wr;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    task automatic release_all();
        logic [7:0] slot;
        for (int i = 0; i < SLOTS; i++) begin
            slot = i[7:0];
            if (tag_busy[slot]) begin
                send_request(FUNC_RELEASE, holder_kind[slot], holder_owner[slot],
                             slot[7:4], slot[3:0]);
            end
        end
    endtask

    function automatic int find_busy_slot();
        int base;
        base = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < SLOTS; i++) begin
            if (tag_busy[(base + i) % SLOTS]) return (base + i) % SLOTS;
        end
        return -1;
    endfunction

    // Mostly admits and matching releases, with some mismatched releases and noise.
    task automatic random_request();
        int         pick;
        int         found;
        logic [7:0] slot;
        pick  = $urandom_range(0, 99);
        found = find_busy_slot();
        slot  = found[7:0];
        if (pick < 50 || found < 0) begin
            send_request(FUNC_ADMIT, 1'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
        end else if (pick < 88) begin
            send_request(FUNC_RELEASE, holder_kind[slot], holder_owner[slot],
                         slot[7:4], slot[3:0]);
        end else if (pick < 91) begin
            if ($urandom_range(0, 1) == 0) begin
                send_request(FUNC_RELEASE, ~holder_kind[slot], holder_owner[slot],
                             slot[7:4], slot[3:0]);
            end else begin
                send_request(FUNC_RELEASE, holder_kind[slot],
                             holder_owner[slot] ^ 4'($urandom_range(1, 15)),
                             slot[7:4], slot[3:0]);
            end
        end else begin
            send_request(1'($urandom), 1'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
        end
    endtask

    // Every tag slot admitted as a read drives the read total to 256, the top bit of its 9-bit field.
    task automatic test_fill_table();
        logic [7:0] slot;
        apply_limits(9'd255, 9'd255, 9'd256, 9'd256);
        for (int i = 0; i < SLOTS; i++) begin
            slot = i[7:0];
            send_request(FUNC_ADMIT, KIND_READ, slot[3:0] ^ slot[7:4], slot[7:4], slot[3:0]);
        end
        send_request(FUNC_ADMIT, KIND_WRITE, 4'd9, 4'd0, 4'd0);
        release_all();
    endtask

    task automatic test_basic_outcomes();
        apply_limits(CFG_DATA_W'(RST_OWNER_READ_LIMIT), CFG_DATA_W'(RST_OWNER_WRITE_LIMIT),
                     RST_GLOBAL_READ_LIMIT, RST_GLOBAL_WRITE_LIMIT);
        send_request(FUNC_RELEASE, KIND_READ, 4'd0, 4'd0, 4'd0);
        send_request(FUNC_ADMIT, KIND_READ, 4'd15, 4'd15, 4'd15);
        send_request(FUNC_ADMIT, KIND_READ, 4'd15, 4'd15, 4'd15);
        send_request(FUNC_ADMIT, KIND_WRITE, 4'd0, 4'd0, 4'd0);
        send_request(FUNC_ADMIT, KIND_WRITE, 4'd0, 4'd0, 4'd1);
        send_request(FUNC_ADMIT, KIND_WRITE, 4'd0, 4'd1, 4'd2);
        // Releases naming the wrong kind or owner must not drive any count below zero.
        send_request(FUNC_RELEASE, KIND_WRITE, 4'd15, 4'd15, 4'd15);
        send_request(FUNC_RELEASE, KIND_READ, 4'd7, 4'd0, 4'd0);
        send_request(FUNC_RELEASE, KIND_WRITE, 4'd0, 4'd0, 4'd1);
        for (int i = 0; i < 5; i++) begin
            send_request(FUNC_ADMIT, KIND_READ, 4'd1, 4'd2, 4'(i));
        end
    endtask

    task automatic test_zero_limits();
        apply_limits(9'd0, 9'd0, 9'd0, 9'd0);
        send_request(FUNC_ADMIT, KIND_READ, 4'd2, 4'd3, 4'd0);
        send_request(FUNC_ADMIT, KIND_WRITE, 4'd2, 4'd3, 4'd1);
        apply_limits(9'd255, 9'd255, 9'd0, 9'd0);
        send_request(FUNC_ADMIT, KIND_READ, 4'd4, 4'd5, 4'd6);
        send_request(FUNC_ADMIT, KIND_WRITE, 4'd4, 4'd5, 4'd7);
        send_request(FUNC_RELEASE, KIND_READ, 4'd1, 4'd2, 4'd0);
    endtask

    task automatic test_global_limit();
        wait_idle();
        release_all();
        apply_limits(9'd255, 9'd255, 9'd2, 9'd1);
        for (int i = 0; i < 3; i++) begin
            send_request(FUNC_ADMIT, KIND_READ, 4'(i + 3), 4'(i), 4'd8);
        end
        send_request(FUNC_ADMIT, KIND_WRITE, 4'd10, 4'd11, 4'd12);
        send_request(FUNC_ADMIT, KIND_WRITE, 4'd13, 4'd14, 4'd15);
        release_all();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase % 2 == 1) begin
                wait_idle();
                release_all();
            end
            case (phase)
                0: apply_limits(9'd4, 9'd2, 9'd64, 9'd16);
                1: apply_limits(9'd255, 9'd255, 9'd256, 9'd256);
                2: apply_limits(9'd1, 9'd1, 9'd3, 9'd2);
                3: apply_limits(9'($urandom), 9'($urandom),
                                9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)));
                4: apply_limits(9'd0, 9'd3, 9'd256, 9'd8);
                default: apply_limits(9'($urandom_range(2, 8)), 9'($urandom_range(1, 6)),
                                      9'($urandom_range(8, 80)), 9'($urandom_range(4, 40)));
            endcase
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // Idle bursts come in chunks; the final phase runs back to back.
                if (n % 50 == 0) idle_gaps = (phase < 5) && ($urandom_range(0, 2) != 0);
                random_request();
            end
        end
        idle_gaps = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_fill_table();
        test_basic_outcomes();
        test_zero_limits();
        test_global_limit();
        test_random_traffic();
        wait_idle();
        repeat (8) @(negedge i_clk);
        $display("Run covered %0d requests and %0d results over %0d limit settings.",
                 requests_taken, results_seen, settings_used);
        $display("Outcomes: %0d admitted, %0d duplicate, %0d owner limit, %0d global limit, %0d %s",
                 status_hits[ST_ADMITTED], status_hits[ST_DUPLICATE],
                 status_hits[ST_OWNER_LIMIT], status_hits[ST_GLOBAL_LIMIT],
                 status_hits[ST_RELEASED] + status_hits[ST_NOT_IN_FLIGHT],
                 "releases, some of tags not in flight");
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/rqc_pkg.sv
design/rqc_ctrl.sv
design/rqc_datapath.sv
design/request_admission_quota_control.sv
dv/testbench.sv
